// ----- src/xrng_pkg.sv -----
// Shared types and constants for the xoshiro256** generator.
package xrng_pkg;

	localparam int unsigned WordW   = 64;
	localparam int unsigned HalfW   = 32;
	localparam int unsigned SeedW   = 32;
	localparam int unsigned FracW   = 53;
	localparam int unsigned NumWords = 4;
	localparam int unsigned IdxW    = 2;

	localparam logic [WordW-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [WordW-1:0] MIX_MUL_A   = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [WordW-1:0] MIX_MUL_B   = 64'h94d0_49bb_1331_11eb;

	localparam logic MODE_DRAW   = 1'b0;
	localparam logic MODE_RESEED = 1'b1;

	localparam logic [IdxW-1:0] LAST_ROUND = IdxW'(NumWords - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_MA0,
		ST_MA1,
		ST_MA2,
		ST_MIX,
		ST_MB0,
		ST_MB1,
		ST_MB2,
		ST_STORE,
		ST_STEP,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD_IN,
		OP_LOAD_POS,
		OP_ADD,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_MIX,
		OP_STORE,
		OP_STEP,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t          op;
		logic            mul_sel_b;
		logic [IdxW-1:0] word_idx;
	} dp_cmd_t;

endpackage

// ----- src/xrng_ctrl.sv -----
// Sequencer for seeding, stepping and result handoff of the generator.
module xrng_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	output logic              out_valid,
	input  logic              out_ready,
	output xrng_pkg::dp_cmd_t cmd
);
	import xrng_pkg::*;

	state_t          state_q;
	state_t          state_next;
	logic [IdxW-1:0] round_q;
	logic            seeded_q;
	logic            draw_pending_q;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_DRAW && seeded_q) begin
						state_next = ST_OUT;
					end else begin
						state_next = ST_ADD;
					end
				end
			end
			ST_ADD:  state_next = ST_MA0;
			ST_MA0:  state_next = ST_MA1;
			ST_MA1:  state_next = ST_MA2;
			ST_MA2:  state_next = ST_MIX;
			ST_MIX:  state_next = ST_MB0;
			ST_MB0:  state_next = ST_MB1;
			ST_MB1:  state_next = ST_MB2;
			ST_MB2:  state_next = ST_STORE;
			ST_STORE: begin
				if (round_q == LAST_ROUND) begin
					state_next = draw_pending_q ? ST_STEP : ST_IDLE;
				end else begin
					state_next = ST_ADD;
				end
			end
			ST_STEP: state_next = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op        = OP_NONE;
		cmd.mul_sel_b = 1'b0;
		cmd.word_idx  = round_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (mode == MODE_RESEED) begin
						cmd.op = OP_LOAD_IN;
					end else if (seeded_q) begin
						cmd.op = OP_STEP;
					end else begin
						cmd.op = OP_LOAD_POS;
					end
				end
			end
			ST_ADD: cmd.op = OP_ADD;
			ST_MA0: cmd.op = OP_MUL0;
			ST_MA1: cmd.op = OP_MUL1;
			ST_MA2: cmd.op = OP_MUL2;
			ST_MIX: cmd.op = OP_MIX;
			ST_MB0: begin
				cmd.op        = OP_MUL0;
				cmd.mul_sel_b = 1'b1;
			end
			ST_MB1: begin
				cmd.op        = OP_MUL1;
				cmd.mul_sel_b = 1'b1;
			end
			ST_MB2: begin
				cmd.op        = OP_MUL2;
				cmd.mul_sel_b = 1'b1;
			end
			ST_STORE: cmd.op = OP_STORE;
			ST_STEP:  cmd.op = OP_STEP;
			ST_OUT: begin
				if (out_free) begin
					cmd.op = OP_OUT;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			round_q        <= '0;
			seeded_q       <= 1'b0;
			draw_pending_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_next;
			case (cmd.op)
				OP_LOAD_IN: begin
					round_q        <= '0;
					seeded_q       <= 1'b1;
					draw_pending_q <= 1'b0;
				end
				OP_LOAD_POS: begin
					round_q        <= '0;
					seeded_q       <= 1'b1;
					draw_pending_q <= 1'b1;
				end
				OP_STORE: round_q <= IdxW'(round_q + 1'b1);
				default: ;
			endcase
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/xrng_dp.sv -----
// Datapath: seed expansion, shared multiplier, generator state and result register.
module xrng_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  xrng_pkg::dp_cmd_t                  cmd,
	input  logic [xrng_pkg::SeedW-1:0]         seed_value,
	input  logic                               cfg_we,
	input  logic [xrng_pkg::SeedW-1:0]         cfg_data,
	output logic [xrng_pkg::WordW-1:0]         random_word,
	output logic [xrng_pkg::FracW-1:0]         unit_fraction
);
	import xrng_pkg::*;

	logic [SeedW-1:0]   power_on_seed_q;
	logic [WordW-1:0]   acc_q;
	logic [WordW-1:0]   z_q;
	logic [WordW-1:0]   prod_q;
	logic [WordW-1:0]   gen_q [NumWords];
	logic [WordW-1:0]   tmp_q;
	logic [WordW-1:0]   word_q;

	logic [WordW-1:0]   acc_next;
	logic [WordW-1:0]   mul_const;
	logic [HalfW-1:0]   mul_a;
	logic [HalfW-1:0]   mul_b;
	logic [WordW-1:0]   mul_p;
	logic [WordW-1:0]   s0_next;
	logic [WordW-1:0]   s1_next;
	logic [WordW-1:0]   s2_next;
	logic [WordW-1:0]   s3_xor;
	logic [WordW-1:0]   s1_times5;

	// The power-on seed register only matters until the first seeding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_seed_q <= '0;
		end else if (cfg_we) begin
			power_on_seed_q <= cfg_data;
		end
	end

	assign acc_next = acc_q + GOLDEN_STEP;

	// One 32x32 multiplier forms the low 64 bits of a 64x64 product in three
	// passes: low*low, then the two cross terms folded into the upper half.
	assign mul_const = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
	assign mul_a     = (cmd.op == OP_MUL2) ? z_q[WordW-1:HalfW] : z_q[HalfW-1:0];
	assign mul_b     = (cmd.op == OP_MUL1) ? mul_const[WordW-1:HalfW]
	                                       : mul_const[HalfW-1:0];
	assign mul_p     = WordW'(mul_a) * WordW'(mul_b);

	assign s1_times5 = gen_q[1] + {gen_q[1][WordW-3:0], 2'b00};
	assign s2_next   = gen_q[2] ^ gen_q[0];
	assign s3_xor    = gen_q[3] ^ gen_q[1];
	assign s1_next   = gen_q[1] ^ s2_next;
	assign s0_next   = gen_q[0] ^ s3_xor;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD_IN:  acc_q <= WordW'(seed_value);
			OP_LOAD_POS: acc_q <= WordW'(power_on_seed_q);
			OP_ADD: begin
				acc_q <= acc_next;
				z_q   <= acc_next ^ (acc_next >> 30);
			end
			OP_MUL0: prod_q <= mul_p;
			OP_MUL1, OP_MUL2: begin
				prod_q[WordW-1:HalfW] <= prod_q[WordW-1:HalfW] + mul_p[HalfW-1:0];
			end
			OP_MIX:   z_q <= prod_q ^ (prod_q >> 27);
			OP_STORE: gen_q[cmd.word_idx] <= prod_q ^ (prod_q >> 31);
			OP_STEP: begin
				tmp_q    <= {s1_times5[WordW-8:0], s1_times5[WordW-1:WordW-7]};
				gen_q[0] <= s0_next;
				gen_q[1] <= s1_next;
				gen_q[2] <= s2_next ^ {gen_q[1][WordW-18:0], 17'b0};
				gen_q[3] <= {s3_xor[WordW-46:0], s3_xor[WordW-1:WordW-45]};
			end
			OP_OUT: word_q <= tmp_q + {tmp_q[WordW-4:0], 3'b000};
			default: ;
		endcase
	end

	assign random_word   = word_q;
	assign unit_fraction = word_q[WordW-1:WordW-FracW];

endmodule

// ----- src/xoshiro256ss_random_generator.sv -----
// Top level of the xoshiro256** random generator with SplitMix64 seeding.
//
// This block holds 256 bits of xoshiro256** state and serves one input
// transaction at a time. A transaction with mode set reseeds the state from
// seed_value by four chained SplitMix64 steps and produces no result; a
// transaction with mode clear draws the next value and produces one result
// transaction carrying the 64-bit output in random_word and its top 53 bits
// in unit_fraction. A draw that arrives before any seeding first seeds the
// state from the power-on seed register, written through the configuration
// channel (cfg_ready is always high); that register has no effect once the
// generator has been seeded, until the next reset. A draw on a seeded
// generator steps the state and then loads the result register, and the next
// transaction is accepted only after that. The seeding time is set by the
// single shared 32x32 multiplier, which builds each of the two 64-bit
// constant products per SplitMix step in three passes. A finished result
// waits in an output register, and the next input transaction is accepted
// while it waits; a draw stalls only if the previous result has still not
// been taken when the new one is ready.
module xoshiro256ss_random_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic [xrng_pkg::SeedW-1:0]     seed_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [xrng_pkg::WordW-1:0]     random_word,
	output logic [xrng_pkg::FracW-1:0]     unit_fraction,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [xrng_pkg::SeedW-1:0]     cfg_data
);
	import xrng_pkg::*;

	dp_cmd_t cmd;

	// The configuration register can be written in any cycle.
	assign cfg_ready = 1'b1;

	xrng_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	xrng_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.seed_value    (seed_value),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.random_word   (random_word),
		.unit_fraction (unit_fraction)
	);

endmodule

// ----- verif/xoshiro256ss_random_generator_tb.sv -----
// Self-checking testbench for the xoshiro256** generator with SplitMix64 seeding.
module xoshiro256ss_random_generator_tb;
	import xrng_pkg::*;

	// SplitMix64 and xoshiro256** constants, kept locally so that the
	// prediction does not lean on the design's own package values.
	localparam logic [63:0] SM_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] SM_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] SM_MUL_B  = 64'h94d0_49bb_1331_11eb;

	// Longest run of cycles without any transaction on any channel.
	localparam int IDLE_LIMIT = 5000;
	// Cycles allowed for the block to finish a reseed that produces no result.
	localparam int SETTLE_CYCLES = 50;
	// Length of the one long receiver hold-off.
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_ITEMS = 60;

	typedef struct {
		logic        m;
		logic [31:0] seed;
	} gen_request_t;

	typedef struct {
		logic [63:0] word;
		logic [52:0] frac;
	} draw_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               mode = MODE_DRAW;
	logic [SeedW-1:0]   seed_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [WordW-1:0]   random_word;
	logic [FracW-1:0]   unit_fraction;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [SeedW-1:0]   cfg_data = '0;

	xoshiro256ss_random_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.seed_value    (seed_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.random_word   (random_word),
		.unit_fraction (unit_fraction),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Predicted generator state, mirroring what the block should hold. It is
	// advanced at the very edge at which the block accepts each transaction.
	logic [63:0]  gen_state [4];
	logic         gen_seeded = 1'b0;
	logic [31:0]  boot_seed = '0;

	gen_request_t pending_requests [$];
	draw_result_t expected_draws [$];
	int           check_errors = 0;

	// Idling controls, set per phase by the stimulus process.
	bit src_idle_en = 1'b0;
	bit sink_idle_en = 1'b0;
	bit long_hold_arm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One SplitMix64 output step applied to an already advanced accumulator.
	function automatic logic [63:0] splitmix_mix(logic [63:0] acc);
		logic [63:0] z;
		z = acc;
		z = (z ^ (z >> 30)) * SM_MUL_A;
		z = (z ^ (z >> 27)) * SM_MUL_B;
		return z ^ (z >> 31);
	endfunction

	// Four chained SplitMix64 steps fill the whole state from a 32-bit seed.
	function automatic void seed_generator(logic [31:0] seed);
		logic [63:0] acc;
		acc = {32'd0, seed};
		for (int n = 0; n < 4; n++) begin
			acc = acc + SM_GOLDEN;
			gen_state[n] = splitmix_mix(acc);
		end
		gen_seeded = 1'b1;
	endfunction

	// Works out the effect of one accepted request. A reseed only replaces
	// the state; a draw seeds from the boot seed if the generator was never
	// seeded, then steps xoshiro256** and queues the value it must output.
	function automatic void predict_request(logic m, logic [31:0] seed);
		logic [63:0] times5;
		logic [63:0] shifted;
		draw_result_t r;
		if (m == MODE_RESEED) begin
			seed_generator(seed);
			return;
		end
		if (!gen_seeded)
			seed_generator(boot_seed);
		// Scrambler: rotate-left by 7 of s1*5, then times 9.
		times5 = gen_state[1] * 64'd5;
		r.word = {times5[56:0], times5[63:57]} * 64'd9;
		r.frac = r.word[63:11];
		shifted = gen_state[1] << 17;
		gen_state[2] = gen_state[2] ^ gen_state[0];
		gen_state[3] = gen_state[3] ^ gen_state[1];
		gen_state[1] = gen_state[1] ^ gen_state[2];
		gen_state[0] = gen_state[0] ^ gen_state[3];
		gen_state[2] = gen_state[2] ^ shifted;
		// Rotate-left by 45.
		gen_state[3] = {gen_state[3][18:0], gen_state[3][63:19]};
		expected_draws.push_back(r);
	endfunction

	// Mostly short gaps, some medium ones and a rare long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic void queue_request(logic m, logic [31:0] seed);
		gen_request_t req;
		req.m = m;
		req.seed = seed;
		pending_requests.push_back(req);
	endfunction

	// Seeds used by the random part: mostly random, now and then an extreme.
	function automatic logic [31:0] pick_seed();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'h0000_0000;
		else if (r == 1)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	// Request driver. The prediction is made at the edge where a transaction
	// is accepted, so it always sees the requests in the block's own order.
	// A new request is offered only when the current one is gone, and valid
	// is assigned at most once per edge.
	always @(posedge clk) begin : request_driver
		gen_request_t req;
		int gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				predict_request(mode, seed_value);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					req = pending_requests.pop_front();
					in_valid <= 1'b1;
					mode <= req.m;
					seed_value <= req.seed;
					if (src_idle_en && $urandom_range(0, 2) == 0)
						gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every accepted result is compared field by field with
	// the oldest predicted draw. The same process also paces out_ready,
	// including the single long hold-off that lets the block back up.
	always @(posedge clk) begin : result_monitor
		draw_result_t want;
		int sink_gap;
		int long_left;
		bit long_used;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_gap = 0;
			long_left = 0;
			long_used = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_draws.size() == 0) begin
					$display("%0t: result with nothing expected, random_word %h unit_fraction %h",
						$time, random_word, unit_fraction);
					check_errors++;
				end else begin
					want = expected_draws.pop_front();
					if (random_word !== want.word) begin
						$display("%0t: random_word mismatch, expected %h actual %h",
							$time, want.word, random_word);
						check_errors++;
					end
					if (unit_fraction !== want.frac) begin
						$display("%0t: unit_fraction mismatch, expected %h actual %h",
							$time, want.frac, unit_fraction);
						check_errors++;
					end
				end
			end
			if (long_hold_arm && !long_used) begin
				long_used = 1'b1;
				long_left = LONG_HOLD_CYCLES;
			end
			if (long_left > 0) begin
				long_left--;
				out_ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ready <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
				sink_gap = pick_gap() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: any transaction on any channel counts as progress.
	always @(posedge clk) begin : stall_watchdog
		int idle_cycles;
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Writes the power-on seed register. Only called while the block is idle,
	// so the predicted copy is updated at the accepting edge.
	task automatic write_boot_seed(logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		boot_seed = value;
	endtask

	// Waits until every queued request has gone in and every predicted draw
	// has come out, then leaves time for a trailing reseed to finish.
	task automatic wait_until_drained();
		@(negedge clk);
		while (pending_requests.size() > 0 || in_valid || expected_draws.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] first_seed;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Several settings right after reset; only the last one is in effect
		// when the first draw arrives, and it is picked among the extremes
		// and a random value.
		write_boot_seed(32'h0000_0000);
		write_boot_seed(32'hffff_ffff);
		case ($urandom_range(0, 2))
			0: first_seed = 32'h0000_0000;
			1: first_seed = 32'hffff_ffff;
			default: first_seed = $urandom;
		endcase
		write_boot_seed(first_seed);

		// Directed part. The first draw arrives before any seeding, so the
		// block must seed itself from the power-on seed. Then reseeds with
		// extreme and single-bit seeds, back-to-back reseeds, and draws.
		@(negedge clk);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_DRAW, 32'hffff_ffff);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_RESEED, 32'h0000_0000);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_RESEED, 32'hffff_ffff);
		queue_request(MODE_DRAW, 32'hffff_ffff);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_RESEED, 32'h0000_0001);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_RESEED, 32'h8000_0000);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_RESEED, 32'h5555_5555);
		queue_request(MODE_RESEED, 32'haaaa_aaaa);
		queue_request(MODE_DRAW, 32'h0);
		queue_request(MODE_RESEED, $urandom);
		queue_request(MODE_DRAW, $urandom);
		queue_request(MODE_DRAW, 32'h0);
		wait_until_drained();

		// Random phases. Each phase uses its own idling pattern, including
		// stretches with no idling at all; between phases the sender waits
		// for every result and the register is rewritten, which must not
		// disturb the already seeded generator.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 3)
				0: write_boot_seed(32'h0000_0000);
				1: write_boot_seed(32'hffff_ffff);
				default: write_boot_seed($urandom);
			endcase
			@(negedge clk);
			src_idle_en = (p % 4 == 1) || (p % 4 == 3);
			sink_idle_en = (p % 4 == 2) || (p % 4 == 3);
			if (p == 5) begin
				// Back-pressure phase: the receiver holds off for a long
				// stretch while draws keep coming with no gaps, so the
				// output register fills and the input must stall.
				src_idle_en = 1'b0;
				long_hold_arm = 1'b1;
				for (int i = 0; i < PHASE_ITEMS; i++)
					queue_request(MODE_DRAW, $urandom);
			end else begin
				for (int i = 0; i < PHASE_ITEMS; i++) begin
					if ($urandom_range(0, 7) == 0)
						queue_request(MODE_RESEED, pick_seed());
					else
						queue_request(MODE_DRAW, $urandom);
				end
			end
			wait_until_drained();
		end

		if (check_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ----- xoshiro256ss_random_generator.f -----
src/xrng_pkg.sv
src/xrng_ctrl.sv
src/xrng_dp.sv
src/xoshiro256ss_random_generator.sv
verif/xoshiro256ss_random_generator_tb.sv
